// ----- hw/rtl/lph_pkg.sv -----
// Shared types, constants and helpers for the lower pH inhibition block.
package lph_pkg;

  // Default fixed-point formats.
  localparam int PH_FRAC_BITS_DEF   = 12;
  localparam int OUT_FRAC_BITS_DEF  = 15;
  localparam int CONC_FRAC_BITS_DEF = 54;

  // Port widths.
  localparam int PH_W   = 16;
  localparam int CONC_W = 64;
  localparam int OUT_W  = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LOWER = 2'd1;
  localparam logic [IDX_W-1:0] REG_UPPER = 2'd2;

  // Reset values of the limits.
  localparam logic [PH_W-1:0] LOWER_RST = 16'd24576;
  localparam logic [PH_W-1:0] UPPER_RST = 16'd28672;

  // round(log10(2) * 2^32)
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_EXP,
    KIND_ONE,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    logic [PH_W-1:0] ph;
    logic            flag;
  } side_t;

  typedef struct packed {
    side_t side;
    kind_t kind;
  } fct_t;

  // Factor code for 1.0, saturated to the field.
  function automatic logic [OUT_W-1:0] one_code(input int ofb);
    logic [OUT_W-1:0] r;
    if (ofb >= OUT_W) begin
      r = '1;
    end else begin
      r = OUT_W'(32'd1 << ofb);
    end
    return r;
  endfunction

  // Reciprocal multipliers: floor(p * recip(d) / 2^32) == floor(p / d) for p < 2^31.
  function automatic logic [32:0] recip(input int d);
    logic [32:0] r;
    case (d)
      1:       r = 33'h1_0000_0000;
      2:       r = 33'h0_8000_0000;
      3:       r = 33'd1431655766;
      4:       r = 33'h0_4000_0000;
      5:       r = 33'd858993460;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/lph_if.sv -----
// Valid/ready channel interfaces for input cells and results.
interface lph_in_if;
  logic                        valid;
  logic                        ready;
  logic [lph_pkg::PH_W-1:0]    ph_value;
  logic [lph_pkg::CONC_W-1:0]  ion_concentration;

  modport source (output valid, ph_value, ion_concentration, input ready);
  modport sink   (input valid, ph_value, ion_concentration, output ready);
endinterface

interface lph_out_if;
  logic                      valid;
  logic                      ready;
  logic [lph_pkg::OUT_W-1:0] inhibition_factor;
  logic [lph_pkg::PH_W-1:0]  ph_used;
  logic                      range_flag;

  modport source (output valid, inhibition_factor, ph_used, range_flag, input ready);
  modport sink   (input valid, inhibition_factor, ph_used, range_flag, output ready);
endinterface

// ----- hw/rtl/lph_log.sv -----
// pH front end: saturates direct pH or converts concentration to pH by log2 squaring.
module lph_log #(
  parameter int PH_FRAC_BITS   = lph_pkg::PH_FRAC_BITS_DEF,
  parameter int CONC_FRAC_BITS = lph_pkg::CONC_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic                       mode,
  input  logic [lph_pkg::PH_W-1:0]   ph_value,
  input  logic [lph_pkg::CONC_W-1:0] conc,
  output logic                       out_valid,
  output lph_pkg::side_t             out_side
);

  localparam int NSQ = 24;
  localparam logic [63:0] PhFull  = (64'd16 << PH_FRAC_BITS) - 64'd1;
  localparam logic [63:0] PhMaxW  = (PhFull > 64'hFFFF) ? 64'hFFFF : PhFull;
  localparam logic [15:0] PhMax   = PhMaxW[15:0];
  localparam int          Shift   = 56 - PH_FRAC_BITS;
  localparam logic [63:0] RndHalf = 64'd1 << (Shift - 1);

  // Stage A: leading one and direct pH saturation.
  logic                 a_v, a_mode, a_zero;
  logic [63:0]          a_c;
  logic [5:0]           a_e, e_n;
  lph_pkg::side_t       a_pside, pside_n;

  always_comb begin
    e_n = '0;
    for (int i = 0; i < 64; i++) begin
      if (conc[i]) begin
        e_n = 6'(i);
      end
    end
    if (ph_value > PhMax) begin
      pside_n = '{ph: PhMax, flag: 1'b1};
    end else begin
      pside_n = '{ph: ph_value, flag: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode  <= mode;
      a_zero  <= (conc == '0);
      a_c     <= conc;
      a_e     <= e_n;
      a_pside <= pside_n;
    end
  end

  // Squaring chain, index 0 is the normalized mantissa.
  logic [30:0]    sq_x    [NSQ+1];
  logic [23:0]    sq_frac [NSQ+1];
  logic [5:0]     sq_e    [NSQ+1];
  logic           sq_zero [NSQ+1];
  logic           sq_mode [NSQ+1];
  logic           sq_v    [NSQ+1];
  lph_pkg::side_t sq_ps   [NSQ+1];
  logic [30:0]    x_n;

  always_comb begin
    if (a_e >= 6'd30) begin
      x_n = 31'(a_c >> (a_e - 6'd30));
    end else begin
      x_n = 31'(a_c << (6'd30 - a_e));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]    <= x_n;
      sq_frac[0] <= '0;
      sq_e[0]    <= a_e;
      sq_zero[0] <= a_zero;
      sq_mode[0] <= a_mode;
      sq_ps[0]   <= a_pside;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] y;
    assign prod = 62'(sq_x[k]) * 62'(sq_x[k]);
    assign y    = prod[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // x in [2,4): halve and emit a one
        sq_x[k+1]    <= y[31] ? y[31:1] : y[30:0];
        sq_frac[k+1] <= {sq_frac[k][22:0], y[31]};
        sq_e[k+1]    <= sq_e[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_mode[k+1] <= sq_mode[k];
        sq_ps[k+1]   <= sq_ps[k];
      end
    end
  end

  // Stage M: scale log2 by log10(2).
  logic signed [7:0]  ediff;
  logic signed [31:0] l24;
  logic signed [63:0] m_prod;
  logic               m_v, m_zero, m_mode;
  lph_pkg::side_t     m_ps;

  assign ediff = $signed({2'b00, sq_e[NSQ]}) - 8'(CONC_FRAC_BITS);
  assign l24   = $signed({ediff, sq_frac[NSQ]});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= l24 * $signed(lph_pkg::LOG10_2_Q32);
      m_zero <= sq_zero[NSQ];
      m_mode <= sq_mode[NSQ];
      m_ps   <= sq_ps[NSQ];
    end
  end

  // Stage F: pH = 3 - log10(c), round and saturate.
  logic signed [63:0] ph56;
  logic [63:0]        phr;
  lph_pkg::side_t     cside;

  assign ph56 = (64'sd3 <<< 56) - m_prod;
  assign phr  = ($unsigned(ph56) + RndHalf) >> Shift;

  always_comb begin
    if (m_zero) begin
      cside = '{ph: PhMax, flag: 1'b1};
    end else if (ph56[63]) begin
      cside = '{ph: '0, flag: 1'b1};
    end else if (phr > PhMaxW) begin
      cside = '{ph: PhMax, flag: 1'b1};
    end else begin
      cside = '{ph: phr[15:0], flag: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= m_mode ? cside : m_ps;
    end
  end

endmodule

// ----- hw/rtl/lph_div.sv -----
// Classifies pH against the limits and divides 3*d^2 by w^2, one quotient bit per stage.
module lph_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  lph_pkg::side_t           in_side,
  input  logic [lph_pkg::PH_W-1:0] lower,
  input  logic [lph_pkg::PH_W-1:0] upper,
  output logic                     out_valid,
  output lph_pkg::fct_t            out_fct,
  output logic [33:0]              out_q,
  output logic                     out_ovf
);

  localparam int NQ = 34;

  // Stage P: classify, form distances.
  logic              p_v;
  lph_pkg::fct_t     p_fct;
  logic [15:0]       p_d, p_w;
  lph_pkg::kind_t    kind_n;

  always_comb begin
    if (in_side.ph >= upper) begin
      kind_n = lph_pkg::KIND_ONE;
    end else if (upper <= lower) begin
      kind_n = lph_pkg::KIND_ZERO;
    end else begin
      kind_n = lph_pkg::KIND_EXP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_fct <= '{side: in_side, kind: kind_n};
      p_d   <= upper - in_side.ph;
      p_w   <= upper - lower;
    end
  end

  // Stage Q: squares.
  logic          q_v;
  lph_pkg::fct_t q_fct;
  logic [31:0]   q_dd, q_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (en) begin
      q_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_fct <= p_fct;
      q_dd  <= 32'(p_d) * 32'(p_d);
      q_den <= 32'(p_w) * 32'(p_w);
    end
  end

  // Stage R: numerator with half divisor for rounding; check quotient fits 34 bits.
  logic [61:0]   num;
  assign num = (62'(34'(q_dd) * 34'd3) << 28) + 62'(q_den >> 1);

  logic [31:0]   dv_rem [NQ+1];
  logic [33:0]   dv_low [NQ+1];
  logic [31:0]   dv_den [NQ+1];
  logic [33:0]   dv_q   [NQ+1];
  logic          dv_ovf [NQ+1];
  logic          dv_v   [NQ+1];
  lph_pkg::fct_t dv_fct [NQ+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= 32'(num[61:34]);
      dv_low[0] <= num[33:0];
      dv_den[0] <= q_den;
      dv_q[0]   <= '0;
      dv_ovf[0] <= (32'(num[61:34]) >= q_den);
      dv_fct[0] <= q_fct;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [32:0] r2;
    logic        ge;
    assign r2 = {dv_rem[j], dv_low[j][NQ-1-j]};
    assign ge = (r2 >= {1'b0, dv_den[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j+1] <= ge ? 32'(r2 - {1'b0, dv_den[j]}) : r2[31:0];
        dv_low[j+1] <= dv_low[j];
        dv_den[j+1] <= dv_den[j];
        dv_q[j+1]   <= {dv_q[j][32:0], ge};
        dv_ovf[j+1] <= dv_ovf[j];
        dv_fct[j+1] <= dv_fct[j];
      end
    end
  end

  assign out_valid = dv_v[NQ];
  assign out_fct   = dv_fct[NQ];
  assign out_q     = dv_q[NQ];
  assign out_ovf   = dv_ovf[NQ];

endmodule

// ----- hw/rtl/lph_exp.sv -----
// exp(-t) as a Horner series of exp(-t/256) followed by eight squarings.
module lph_exp #(
  parameter int OUT_FRAC_BITS = lph_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  lph_pkg::fct_t             in_fct,
  input  logic [33:0]               in_q,
  input  logic                      in_ovf,
  output logic                      out_valid,
  output lph_pkg::side_t            out_side,
  output logic [lph_pkg::OUT_W-1:0] out_factor
);

  localparam int          NH      = 5;
  localparam int          NS      = 8;
  localparam logic [15:0] OneCode = lph_pkg::one_code(OUT_FRAC_BITS);
  localparam logic [31:0] FinRnd  = 32'd1 << (30 - OUT_FRAC_BITS);
  localparam logic [63:0] MulRnd  = 64'd1 << 30;

  // Stage E0: drop far-below cases, form u = t/256 in Q31.
  logic           hb_v   [NH+1];
  logic [28:0]    hb_u   [NH+1];
  logic [31:0]    hb_a   [NH+1];
  lph_pkg::fct_t  hb_fct [NH+1];
  lph_pkg::fct_t  fct_n;

  always_comb begin
    fct_n = in_fct;
    if (in_fct.kind == lph_pkg::KIND_EXP && (in_ovf || in_q[33])) begin
      fct_n.kind = lph_pkg::KIND_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_v[0] <= 1'b0;
    end else if (en) begin
      hb_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hb_u[0]   <= 29'((34'(in_q[32:0]) + 34'd16) >> 5);
      hb_a[0]   <= lph_pkg::ONE_Q31;
      hb_fct[0] <= fct_n;
    end
  end

  // Horner steps: a = 1 - (u*a)/D for D = 5 down to 1.
  for (genvar h = 0; h < NH; h++) begin : g_horner
    localparam logic [32:0] Recip = lph_pkg::recip(NH - h);
    logic          m_v, r_v;
    logic [29:0]   m_p;
    logic [30:0]   r_r;
    logic [28:0]   m_u, r_u;
    lph_pkg::fct_t m_fct, r_fct;
    logic [63:0]   mprod;
    logic [62:0]   rprod;

    assign mprod = (64'(hb_u[h]) * 64'(hb_a[h])) + MulRnd;
    assign rprod = 63'(m_p) * 63'(Recip);

    always_ff @(posedge clk) begin
      if (rst) begin
        m_v       <= 1'b0;
        r_v       <= 1'b0;
        hb_v[h+1] <= 1'b0;
      end else if (en) begin
        m_v       <= hb_v[h];
        r_v       <= m_v;
        hb_v[h+1] <= r_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_p         <= mprod[60:31];
        m_u         <= hb_u[h];
        m_fct       <= hb_fct[h];
        r_r         <= rprod[62:32];
        r_u         <= m_u;
        r_fct       <= m_fct;
        hb_a[h+1]   <= lph_pkg::ONE_Q31 - 32'(r_r);
        hb_u[h+1]   <= r_u;
        hb_fct[h+1] <= r_fct;
      end
    end
  end

  // Eight squarings raise exp(-u) to exp(-256u).
  logic          sq_v   [NS+1];
  logic [31:0]   sq_a   [NS+1];
  lph_pkg::fct_t sq_fct [NS+1];

  assign sq_v[0]   = hb_v[NH];
  assign sq_a[0]   = hb_a[NH];
  assign sq_fct[0] = hb_fct[NH];

  for (genvar s = 0; s < NS; s++) begin : g_sq
    logic [63:0] prod;
    assign prod = (64'(sq_a[s]) * 64'(sq_a[s])) + MulRnd;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[s+1] <= 1'b0;
      end else if (en) begin
        sq_v[s+1] <= sq_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_a[s+1]   <= prod[62:31];
        sq_fct[s+1] <= sq_fct[s];
      end
    end
  end

  // Final rounding to the output format.
  logic [32:0] rsum;
  logic [32:0] rval;
  logic [15:0] fac_n;

  assign rsum = 33'(sq_a[NS]) + 33'(FinRnd);
  assign rval = rsum >> (31 - OUT_FRAC_BITS);

  always_comb begin
    case (sq_fct[NS].kind)
      lph_pkg::KIND_ONE:  fac_n = OneCode;
      lph_pkg::KIND_ZERO: fac_n = '0;
      lph_pkg::KIND_EXP:  fac_n = (rval > 33'h0FFFF) ? 16'hFFFF : rval[15:0];
      default:            fac_n = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side   <= sq_fct[NS].side;
      out_factor <= fac_n;
    end
  end

endmodule

// ----- hw/rtl/lower_ph_switch_inhibition.sv -----
// Top level of the lower pH switch inhibition pipeline.
//
// Takes one cell per clock unless stalled and returns one result per cell, in
// order (28 stages for the pH front end, whose 24 log2 squarings dominate, 37
// for the limit check and the bit-per-stage divider of 3*d^2 by w^2, 25 for
// the exp series, its eight squarings and the output register). Sustained rate
// is one transfer per cycle unless stalled. In pH mode ph_value is saturated
// to the largest pH code; in concentration mode pH = 3 - log10(c) is formed
// from ion_concentration, and a zero or out-of-range concentration saturates
// and raises range_flag. The factor is 1.0 at or above the upper limit, zero
// when the limits are not ordered, else exp(-3*((upper-pH)/(upper-lower))^2).
// The whole pipeline advances together: it holds when the output register is
// full and not taken, so the input is ready whenever the output can move.
// Write configuration only while no cell is in flight.
module lower_ph_switch_inhibition #(
  parameter int PH_FRAC_BITS   = lph_pkg::PH_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS  = lph_pkg::OUT_FRAC_BITS_DEF,
  parameter int CONC_FRAC_BITS = lph_pkg::CONC_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  lph_in_if.sink                      in_ch,
  lph_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [lph_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lph_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [63:0] PhFull = (64'd16 << PH_FRAC_BITS) - 64'd1;
  localparam logic [15:0] PhMax  = (PhFull > 64'hFFFF) ? 16'hFFFF : PhFull[15:0];
  localparam logic [15:0] OneCode = lph_pkg::one_code(OUT_FRAC_BITS);

  // Configuration registers.
  logic                      conc_mode;
  logic [lph_pkg::PH_W-1:0]  ph_lower;
  logic [lph_pkg::PH_W-1:0]  ph_upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      conc_mode <= 1'b0;
      ph_lower  <= lph_pkg::LOWER_RST;
      ph_upper  <= lph_pkg::UPPER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lph_pkg::REG_MODE:  conc_mode <= cfg_data[0];
        lph_pkg::REG_LOWER: ph_lower  <= cfg_data;
        lph_pkg::REG_UPPER: ph_upper  <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Advance every stage when the output register is empty or being taken.
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic           log_v;
  lph_pkg::side_t log_side;

  lph_log #(
    .PH_FRAC_BITS   (PH_FRAC_BITS),
    .CONC_FRAC_BITS (CONC_FRAC_BITS)
  ) u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_ch.valid),
    .mode      (conc_mode),
    .ph_value  (in_ch.ph_value),
    .conc      (in_ch.ion_concentration),
    .out_valid (log_v),
    .out_side  (log_side)
  );

  logic          div_v;
  lph_pkg::fct_t div_fct;
  logic [33:0]   div_q;
  logic          div_ovf;

  lph_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (log_v),
    .in_side   (log_side),
    .lower     (ph_lower),
    .upper     (ph_upper),
    .out_valid (div_v),
    .out_fct   (div_fct),
    .out_q     (div_q),
    .out_ovf   (div_ovf)
  );

  lph_pkg::side_t exp_side;

  lph_exp #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_exp (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (div_v),
    .in_fct     (div_fct),
    .in_q       (div_q),
    .in_ovf     (div_ovf),
    .out_valid  (out_ch.valid),
    .out_side   (exp_side),
    .out_factor (out_ch.inhibition_factor)
  );

  assign out_ch.ph_used    = exp_side.ph;
  assign out_ch.range_flag = exp_side.flag;

  // The factor never exceeds the code for 1.0.
  a_factor_max: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.inhibition_factor <= OneCode)
    else $error("inhibition factor above 1.0");

  // A flagged pH is always one of the saturation codes.
  a_flag_sat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.range_flag |-> out_ch.ph_used == 16'd0 || out_ch.ph_used == PhMax)
    else $error("range flag on an unsaturated pH");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
